// ===== rtl/bms_pkg.sv =====
// Shared constants, types and codes for the ranged bitmap set.
package bms_pkg;

    // Set geometry
    localparam int MAX_LEN   = 4096;
    localparam int WORD_BITS = 8;
    localparam int NUM_WORDS = (MAX_LEN + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = $clog2(NUM_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int SWEEP_W   = ADDR_W + 1;

    // Field widths
    localparam int VAL_W = 32;
    localparam int LEN_W = 13;
    localparam int CNT_W = 13;

    // Configuration register indexes
    localparam logic REG_RANGE_LOW  = 1'b0;
    localparam logic REG_SET_LENGTH = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_W-1:0]    t_addr;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TEST   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RMW   = 4'b0100,
        ST_CLEAR = 4'b1000
    } t_state;

    // Result of the range check: where the value's bit lives
    typedef struct packed {
        logic             in_range;
        t_addr            word;
        logic [BIT_W-1:0] bit_sel;
    } t_lookup;

endpackage

// ===== rtl/bms_ram.sv =====
// Bitmap word store: one write port, one read port with registered data.
module bms_ram
    import bms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_word i_wdata,
    input  logic  i_re,
    input  t_addr i_raddr,
    output t_word o_rdata
);

    t_word r_mem [NUM_WORDS];
    t_word r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bms_range.sv =====
// Range check: offset of a value from the range base, bounds test, word and bit.
module bms_range
    import bms_pkg::*;
(
    input  logic [VAL_W-1:0] i_value,
    input  logic [VAL_W-1:0] i_range_low,
    input  logic [LEN_W-1:0] i_eff_len,
    output t_lookup          o_lookup
);

    logic [VAL_W:0] diff;

    // Signed difference, one bit wider so it cannot wrap
    assign diff = {i_value[VAL_W-1], i_value} - {i_range_low[VAL_W-1], i_range_low};

    always_comb begin
        o_lookup.in_range = !diff[VAL_W] && (diff[VAL_W-1:0] < VAL_W'(i_eff_len));
        o_lookup.word     = diff[BIT_W +: ADDR_W];
        o_lookup.bit_sel  = diff[BIT_W-1:0];
    end

endmodule

// ===== rtl/ranged_bitmap_set.sv =====
// Ranged bitmap set top level: command sequencing, count and configuration.
//
// Add, remove and test: the range check and bitmap word read happen in the
// start cycle, the bit update and write-back in the next, set by the
// registered read port of the bitmap memory. Clear zeroes ceil(len/8)
// memory words, one memory word zeroed per cycle. After reset the block
// sweeps all 512 words to zero, keeping busy high; configuration writes
// are taken at any time (o_cfg_ready is always high) but should only be
// issued while idle. Each result shows on the o_done strobe for one cycle,
// in the cycle after the last busy cycle; the receiver cannot stall it.
module ranged_bitmap_set
    import bms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [1:0]       i_command,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_done,
    output logic             o_status,
    output logic             o_present,
    output logic [CNT_W-1:0] o_count,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [31:0]      i_cfg_data
);

    t_state           r_state, n_state;
    logic [VAL_W-1:0] r_range_low;
    logic [LEN_W-1:0] r_set_length;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SWEEP_W-1:0] r_sweep, n_sweep;
    t_cmd             r_cmd;
    t_lookup          r_look;
    logic             r_done, n_done;
    logic             r_status, n_status;
    logic             r_present, n_present;

    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W:0]     len_round;
    logic [SWEEP_W-1:0] used_words;
    t_lookup            look;
    logic               accept;
    logic               mem_we, mem_re;
    t_addr              mem_waddr;
    t_word              mem_wdata, mem_rdata, bit_mask;
    logic               cur_present;

    // Effective length saturates at MAX_LEN; clear covers ceil(len/8) words
    assign eff_len    = (r_set_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : r_set_length;
    assign len_round  = {1'b0, eff_len} + (LEN_W+1)'(WORD_BITS - 1);
    assign used_words = len_round[BIT_W +: SWEEP_W];

    assign o_busy      = (r_state != ST_IDLE);
    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;

    bms_range u_range (
        .i_value     (i_value),
        .i_range_low (r_range_low),
        .i_eff_len   (eff_len),
        .o_lookup    (look)
    );

    // Word read is issued in the start cycle
    assign mem_re = accept && look.in_range && (t_cmd'(i_command) != CMD_CLEAR);

    bms_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (look.word),
        .o_rdata (mem_rdata)
    );

    assign bit_mask    = t_word'(1) << r_look.bit_sel;
    assign cur_present = |(mem_rdata & bit_mask);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_set_length <= LEN_W'(MAX_LEN);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                REG_SET_LENGTH: r_set_length <= i_cfg_data[LEN_W-1:0];
                default:        r_range_low  <= r_range_low;
            endcase
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_command);
            r_look <= look;
        end
    end

    // Sequencer: init sweep, read-modify-write, clear sweep
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sweep   = r_sweep;
        n_done    = 1'b0;
        n_status  = r_status;
        n_present = r_present;
        mem_we    = 1'b0;
        mem_waddr = r_look.word;
        mem_wdata = mem_rdata;
        case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep[ADDR_W-1:0];
                mem_wdata = '0;
                n_sweep   = r_sweep + 1'b1;
                if (r_sweep == SWEEP_W'(NUM_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_sweep = '0;
                if (accept) begin
                    n_state = (t_cmd'(i_command) == CMD_CLEAR) ? ST_CLEAR : ST_RMW;
                end
            end
            ST_RMW: begin
                n_state   = ST_IDLE;
                n_done    = 1'b1;
                n_status  = !r_look.in_range;
                n_present = r_look.in_range && cur_present;
                if (r_look.in_range) begin
                    case (r_cmd)
                        CMD_ADD: begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata | bit_mask;
                            if (!cur_present && (r_count < CNT_W'(MAX_LEN))) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            mem_we    = 1'b1;
                            mem_wdata = mem_rdata & ~bit_mask;
                            if (cur_present && (r_count != '0)) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: mem_we = 1'b0;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (r_sweep == used_words) begin
                    n_state   = ST_IDLE;
                    n_done    = 1'b1;
                    n_status  = 1'b0;
                    n_present = 1'b0;
                    n_count   = '0;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_sweep[ADDR_W-1:0];
                    mem_wdata = '0;
                    n_sweep   = r_sweep + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_count <= '0;
            r_sweep <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sweep <= n_sweep;
            r_done  <= n_done;
        end
    end

    // Result flags
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_present <= n_present;
    end

    assign o_done    = r_done;
    assign o_status  = r_status;
    assign o_present = r_present;
    assign o_count   = r_count;

    // Out-of-range results never report a member
    a_status_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status |-> !o_present)
        else $error("out-of-range result reports present");

    // Count only moves together with a result
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |-> o_done)
        else $error("member count changed without a result");

    // Out-of-range leaves the count alone
    a_oor_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_done && o_status |-> r_count == $past(r_count))
        else $error("out-of-range command changed the count");

    // Read-modify-write is followed in the next cycle by a result and idle
    a_rmw_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RMW |=> o_done && (r_state == ST_IDLE))
        else $error("read-modify-write did not complete");

    // Count never exceeds the set capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("member count above capacity");

endmodule
